[src/tptz_pkg.sv]
`timescale 1ns / 1ps

package tptz_pkg;

  localparam int ERROR_W   = 16;
  localparam int COEF_W    = 20;
  localparam int DUTY_W    = 15;
  localparam int ERR_ALIGN = 3;
  localparam int OUT_SHIFT = 14;
  localparam int PROD_W    = ERROR_W + COEF_W;
  // three aligned error products plus two duty products, with margin
  localparam int ACC_W     = PROD_W + ERR_ALIGN + 3;
  localparam int Y_W       = ACC_W - OUT_SHIFT;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CAP = 3'd5;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST  = 20'sd84066;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST  = -20'sd163217;
  localparam logic signed [COEF_W-1:0] COEF_B2_RST  = 20'sd79217;
  localparam logic signed [COEF_W-1:0] COEF_A1_RST  = 20'sd11660;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST  = 20'sd4724;
  localparam logic [DUTY_W-1:0]        DUTY_CAP_RST = 15'd14746;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [DUTY_W-1:0]        duty_cap;
  } coef_set_t;

  typedef struct packed {
    logic signed [ERROR_W-1:0] error_prev1;
    logic signed [ERROR_W-1:0] error_prev2;
    logic [DUTY_W-1:0]         duty_prev1;
    logic [DUTY_W-1:0]         duty_prev2;
  } hist_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              hit_max;
    logic              hit_zero;
  } result_t;

endpackage

[src/two_pole_two_zero_compensator.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted input word waits in the input register, then moves to the
// result register, read from out_; back-pressure on out_tready stalls it in between.
// Throughput: one word per cycle while out_tready does not stall; the multiply-
// accumulate loop through the duty history register sets that figure.
// Reset (rst_n low, synchronous): history cleared, coefficients and duty cap
// return to their defaults, both pipeline registers emptied.

module two_pole_two_zero_compensator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,   // [15:0] error
  input  logic [0:0]                          in_tuser,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // [14:0] duty, [15] zero
  output logic [1:0]                          out_tuser,  // [0] hit_max, [1] hit_zero
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tptz_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tptz_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tptz_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  tptz_pkg::coef_set_t                 coefs_r;
  tptz_pkg::hist_t                     hist_r, hist_nxt;
  tptz_pkg::result_t                   result_nxt, result_r;
  logic                                stage_valid_r, out_valid_r;
  logic signed [tptz_pkg::ERROR_W-1:0] error_r;
  logic                                restart_r;
  logic                                advance;
  logic                                cfg_wr;
  logic [tptz_pkg::CFG_IDX_W-1:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[tptz_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0       <= tptz_pkg::COEF_B0_RST;
      coefs_r.b1       <= tptz_pkg::COEF_B1_RST;
      coefs_r.b2       <= tptz_pkg::COEF_B2_RST;
      coefs_r.a1       <= tptz_pkg::COEF_A1_RST;
      coefs_r.a2       <= tptz_pkg::COEF_A2_RST;
      coefs_r.duty_cap <= tptz_pkg::DUTY_CAP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tptz_pkg::REG_COEF_B0:  coefs_r.b0 <= cfg_pwdata[tptz_pkg::COEF_W-1:0];
        tptz_pkg::REG_COEF_B1:  coefs_r.b1 <= cfg_pwdata[tptz_pkg::COEF_W-1:0];
        tptz_pkg::REG_COEF_B2:  coefs_r.b2 <= cfg_pwdata[tptz_pkg::COEF_W-1:0];
        tptz_pkg::REG_COEF_A1:  coefs_r.a1 <= cfg_pwdata[tptz_pkg::COEF_W-1:0];
        tptz_pkg::REG_COEF_A2:  coefs_r.a2 <= cfg_pwdata[tptz_pkg::COEF_W-1:0];
        tptz_pkg::REG_DUTY_CAP: coefs_r.duty_cap <= cfg_pwdata[tptz_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tptz_pkg::REG_COEF_B0:  cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.b0);
      tptz_pkg::REG_COEF_B1:  cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.b1);
      tptz_pkg::REG_COEF_B2:  cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.b2);
      tptz_pkg::REG_COEF_A1:  cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.a1);
      tptz_pkg::REG_COEF_A2:  cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.a2);
      tptz_pkg::REG_DUTY_CAP: cfg_prdata = tptz_pkg::CFG_DATA_W'(coefs_r.duty_cap);
      default:                cfg_prdata = '0;
    endcase
  end

  // advance the stage word into the result register when that register frees up
  assign advance   = stage_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~stage_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      error_r   <= in_tdata[tptz_pkg::ERROR_W-1:0];
      restart_r <= in_tuser[0];
    end
  end

  tptz_datapath u_datapath (
    .error    (error_r),
    .restart  (restart_r),
    .hist     (hist_r),
    .coefs    (coefs_r),
    .hist_nxt (hist_nxt),
    .result   (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        hist_r <= hist_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, result_r.duty};
  assign out_tuser  = {result_r.hit_zero, result_r.hit_max};

endmodule

[src/tptz_datapath.sv]
`timescale 1ns / 1ps

module tptz_datapath (
  input  logic signed [tptz_pkg::ERROR_W-1:0] error,
  input  logic                                restart,
  input  tptz_pkg::hist_t                     hist,
  input  tptz_pkg::coef_set_t                 coefs,
  output tptz_pkg::hist_t                     hist_nxt,
  output tptz_pkg::result_t                   result
);

  logic signed [tptz_pkg::PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [tptz_pkg::ACC_W-1:0]  err_sum, acc;
  logic signed [tptz_pkg::Y_W-1:0]    y, max_ext;
  logic                               at_max, at_zero;
  logic [tptz_pkg::DUTY_W-1:0]        duty_c;

  assign p_b0 = tptz_pkg::PROD_W'(coefs.b0 * error);
  assign p_b1 = tptz_pkg::PROD_W'(coefs.b1 * hist.error_prev1);
  assign p_b2 = tptz_pkg::PROD_W'(coefs.b2 * hist.error_prev2);
  assign p_a1 = tptz_pkg::PROD_W'(coefs.a1 * $signed({1'b0, hist.duty_prev1}));
  assign p_a2 = tptz_pkg::PROD_W'(coefs.a2 * $signed({1'b0, hist.duty_prev2}));

  assign err_sum = tptz_pkg::ACC_W'(p_b0) + tptz_pkg::ACC_W'(p_b1)
                 + tptz_pkg::ACC_W'(p_b2);
  assign acc = (err_sum <<< tptz_pkg::ERR_ALIGN)
             + tptz_pkg::ACC_W'(p_a1) + tptz_pkg::ACC_W'(p_a2);

  assign y       = tptz_pkg::Y_W'(acc >>> tptz_pkg::OUT_SHIFT);
  assign max_ext = tptz_pkg::Y_W'($signed({1'b0, coefs.duty_cap}));
  assign at_max  = (y >= max_ext);
  assign at_zero = at_max ? (coefs.duty_cap == '0) : (y <= 0);

  always_comb begin
    if (at_zero) begin
      duty_c = '0;
    end else if (at_max) begin
      duty_c = coefs.duty_cap;
    end else begin
      duty_c = y[tptz_pkg::DUTY_W-1:0];
    end
  end

  always_comb begin
    if (restart) begin
      hist_nxt = '0;
      result   = '0;
    end else begin
      hist_nxt.error_prev1 = error;
      hist_nxt.error_prev2 = hist.error_prev1;
      hist_nxt.duty_prev1  = duty_c;
      hist_nxt.duty_prev2  = hist.duty_prev1;
      result.duty          = duty_c;
      result.hit_max       = at_max;
      result.hit_zero      = at_zero;
    end
  end

endmodule
